// ===== sv/sorted_record_table_core_macros.svh =====
// Assertion macros for the sorted record table
`ifndef SORTED_RECORD_TABLE_CORE_MACROS_SVH
`define SORTED_RECORD_TABLE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srt_pkg.sv =====
package srt_pkg;

    localparam int Capacity   = 16;
    localparam int NameBytes  = 30;
    localparam int IdxW       = $clog2(Capacity);
    localparam int CntW       = $clog2(Capacity + 1);
    localparam int NameW      = 256;

    typedef enum logic [2:0] {
        ACT_COUNT   = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_REM_TL  = 3'd2,
        ACT_REM_NM  = 3'd3,
        ACT_READ    = 3'd4,
        ACT_FIND    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } status_t;

    typedef logic [NameW-1:0] name_t;

    // Shared compare unit request and answer
    typedef struct packed {
        logic [15:0] store_key;
        logic [15:0] item_key;
        name_t       store_name;
        name_t       item_name;
    } cmp_req_t;

    typedef struct packed {
        logic key_less;
        logic name_eq;
    } cmp_rsp_t;

    // Zero every byte from the first zero byte or the byte limit onwards
    function automatic name_t canon_name(input name_t src);
        name_t dst;
        logic  ended;
        dst   = '0;
        ended = 1'b0;
        for (int b = 0; b < 32; b++)
        begin
            if (b >= NameBytes || src[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                dst[8*b +: 8] = src[8*b +: 8];
        end
        return dst;
    endfunction

endpackage

// ===== sv/srt_compare.sv =====
module srt_compare
    import srt_pkg::*;
(
    input  cmp_req_t req,
    output cmp_rsp_t rsp
);

    assign rsp.key_less = req.store_key < req.item_key;
    assign rsp.name_eq  = req.store_name == req.item_name;

endmodule

// ===== sv/sorted_record_table_core.sv =====
// Channel | Signals                                         | Direction
// in      | in_valid, in_stall, action, age_key, position,  | into block
//         | name_w0..name_w3                                |
// out     | out_valid, out_stall, status, record_count,     | out of block
//         | found_age, found_name_w0..found_name_w3         |
//
// Sequencing: the scan walks the table one entry a cycle through the shared
//   compare unit; the record shift moves entries with a read and a write each.
// Reset: rst_n clears the count and control; stored records are not cleared.
// Stalls: the result sits in an output register; a new transfer is taken
//   once the previous result has been taken.
`include "sorted_record_table_core_macros.svh"
module sorted_record_table_core
    import srt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [15:0] age_key,
    input  logic [7:0]  position,
    input  logic [63:0] name_w0,
    input  logic [63:0] name_w1,
    input  logic [63:0] name_w2,
    input  logic [63:0] name_w3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [4:0]  record_count,
    output logic [15:0] found_age,
    output logic [63:0] found_name_w0,
    output logic [63:0] found_name_w1,
    output logic [63:0] found_name_w2,
    output logic [63:0] found_name_w3
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_READ,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  ptr_reg;     // walk pointer
    logic [CntW-1:0]  at_reg;      // target slot
    logic [2:0]       act_reg;
    logic [15:0]      key_reg;
    name_t            name_reg;
    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [15:0]      fage_reg;
    name_t            fname_reg;

    // Record store: one write port, one registered read port
    logic [15:0]      key_mem  [Capacity];
    name_t            name_mem [Capacity];
    logic [15:0]      rd_key_reg;
    name_t            rd_name_reg;
    logic             rd_ok_reg;   // read data belongs to ptr_reg - 1 during scan

    logic [IdxW-1:0]  rd_addr;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic [15:0]      wr_key;
    name_t            wr_name;

    cmp_req_t         cmp_req;
    cmp_rsp_t         cmp_rsp;

    srt_compare u_cmp (.req(cmp_req), .rsp(cmp_rsp));

    assign cmp_req.store_key  = rd_key_reg;
    assign cmp_req.item_key   = key_reg;
    assign cmp_req.store_name = rd_name_reg;
    assign cmp_req.item_name  = name_reg;

    assign in_stall      = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign record_count  = 5'(count_reg);
    assign found_age     = fage_reg;
    assign found_name_w0 = fname_reg[63:0];
    assign found_name_w1 = fname_reg[127:64];
    assign found_name_w2 = fname_reg[191:128];
    assign found_name_w3 = fname_reg[255:192];

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    // Read address: scan walks forward, up-shift reads below, down-shift above
    always_comb
    begin
        rd_addr = IdxW'(ptr_reg);
        if (state_reg == S_SHIFT_UP)
            rd_addr = IdxW'(ptr_reg - 1'b1);
        else if (state_reg == S_SHIFT_DN)
            rd_addr = IdxW'(ptr_reg + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[rd_addr];
        rd_name_reg <= name_mem[rd_addr];
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            name_mem[wr_addr] <= wr_name;
        end
    end

    // Shift states alternate a read cycle (rd_ok low) and a write cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = IdxW'(ptr_reg);
        wr_key  = rd_key_reg;
        wr_name = rd_name_reg;
        if ((state_reg == S_SHIFT_UP || state_reg == S_SHIFT_DN) && rd_ok_reg)
            wr_en = 1'b1;
        else if (state_reg == S_SHIFT_UP && !rd_ok_reg && ptr_reg == at_reg)
        begin
            wr_en   = 1'b1;
            wr_key  = key_reg;
            wr_name = name_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            ptr_reg       <= '0;
            at_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    rd_ok_reg <= 1'b0;
                    ptr_reg   <= '0;
                    if (in_xfer)
                    begin
                        act_reg    <= action;
                        key_reg    <= age_key;
                        name_reg   <= canon_name({name_w3, name_w2, name_w1, name_w0});
                        status_reg <= ST_OK;
                        fage_reg   <= '0;
                        fname_reg  <= '0;
                        case (action)
                            ACT_INSERT:
                                if (count_reg == CntW'(Capacity))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_SCAN;
                            ACT_REM_TL:
                            begin
                                if (count_reg == '0)
                                    status_reg <= ST_EMPTY;
                                else
                                    count_reg <= count_reg - 1'b1;
                                state_reg <= S_DONE;
                            end
                            ACT_REM_NM, ACT_FIND:
                                state_reg <= S_SCAN;
                            ACT_READ:
                                if (position == 8'd0 || position > 8'(count_reg))
                                begin
                                    status_reg <= ST_BADPOS;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    ptr_reg   <= CntW'(position - 8'd1);
                                    state_reg <= S_READ;
                                end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_READ:
                begin
                    // Memory read issued last cycle at ptr_reg
                    if (rd_ok_reg)
                    begin
                        fage_reg  <= rd_key_reg;
                        fname_reg <= rd_name_reg;
                        state_reg <= S_DONE;
                    end
                    rd_ok_reg <= 1'b1;
                end
                S_SCAN:
                begin
                    // Entry ptr_reg-1 is in the read register when rd_ok is high
                    if (rd_ok_reg && act_reg == ACT_INSERT && !cmp_rsp.key_less)
                    begin
                        at_reg    <= ptr_reg - 1'b1;
                        ptr_reg   <= count_reg;
                        rd_ok_reg <= 1'b0;
                        state_reg <= S_SHIFT_UP;
                    end
                    else if (rd_ok_reg && act_reg != ACT_INSERT && cmp_rsp.name_eq)
                    begin
                        rd_ok_reg <= 1'b0;
                        if (act_reg == ACT_FIND)
                        begin
                            fage_reg  <= rd_key_reg;
                            fname_reg <= rd_name_reg;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg - 1'b1;
                            state_reg <= S_SHIFT_DN;
                        end
                    end
                    else if (ptr_reg == count_reg)
                    begin
                        rd_ok_reg <= 1'b0;
                        if (act_reg == ACT_INSERT)
                        begin
                            at_reg    <= count_reg;
                            state_reg <= S_SHIFT_UP;
                        end
                        else
                        begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= S_DONE;
                        end
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        rd_ok_reg <= 1'b1;
                    end
                end
                S_SHIFT_UP:
                begin
                    // Move entry ptr-1 into ptr, down to the insert slot
                    if (!rd_ok_reg && ptr_reg == at_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (rd_ok_reg)
                    begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                    else
                        rd_ok_reg <= 1'b1;
                end
                S_SHIFT_DN:
                begin
                    // Move entry ptr+1 into ptr up to the tail
                    if (!rd_ok_reg && ptr_reg + 1'b1 >= count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (rd_ok_reg)
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                    else
                        rd_ok_reg <= 1'b1;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `SRT_ASSERT_IMPL(a_count_cap, 1'b1, count_reg <= CntW'(Capacity),
        "record count beyond capacity")
    `SRT_ASSERT_IMPL(a_no_accept_busy, state_reg != S_IDLE, in_stall,
        "transfer taken while busy")
    `SRT_ASSERT_NEXT(a_count_step, in_xfer && action == ACT_COUNT,
        count_reg == $past(count_reg), "count changed on count action")

endmodule

// ===== dv/sorted_record_table_core_test.sv =====
`timescale 1ns / 100ps

module sorted_record_table_core_test;
    import srt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [15:0] age_key;
    logic [7:0]  position;
    logic [63:0] name_w0;
    logic [63:0] name_w1;
    logic [63:0] name_w2;
    logic [63:0] name_w3;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [4:0]  record_count;
    logic [15:0] found_age;
    logic [63:0] found_name_w0;
    logic [63:0] found_name_w1;
    logic [63:0] found_name_w2;
    logic [63:0] found_name_w3;

    typedef struct {
        status_t     st;
        logic [4:0]  cnt;
        logic [15:0] age;
        name_t       nm;
    } table_answer_t;

    // Own copy of the table, kept in step with every accepted transfer
    logic [15:0]   shadow_keys [Capacity];
    name_t         shadow_names [Capacity];
    int            shadow_count;
    table_answer_t pending_answers [$];
    name_t         name_pool [12];
    int            error_count;
    bit            stall_enable;

    sorted_record_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .age_key       (age_key),
        .position      (position),
        .name_w0       (name_w0),
        .name_w1       (name_w1),
        .name_w2       (name_w2),
        .name_w3       (name_w3),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .record_count  (record_count),
        .found_age     (found_age),
        .found_name_w0 (found_name_w0),
        .found_name_w1 (found_name_w1),
        .found_name_w2 (found_name_w2),
        .found_name_w3 (found_name_w3)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Cut a name at its first zero byte or at the byte limit
    function automatic name_t trim_name(input name_t raw);
        name_t res;
        bit    done;
        res  = '0;
        done = 1'b0;
        for (int b = 0; b < 32; b++)
        begin
            if (b >= NameBytes || raw[8*b +: 8] == 8'h00)
                done = 1'b1;
            if (!done)
                res[8*b +: 8] = raw[8*b +: 8];
        end
        return res;
    endfunction

    function automatic int locate_name(input name_t nm);
        for (int r = 0; r < shadow_count; r++)
        begin
            if (shadow_names[r] == nm)
                return r;
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and give the answer it produces
    function automatic table_answer_t apply_command(input logic [2:0] act,
        input logic [15:0] key, input logic [7:0] pos, input name_t raw);
        table_answer_t ans;
        name_t         nm;
        int            hit;
        int            at;
        nm     = trim_name(raw);
        hit    = -1;
        ans.st = ST_OK;
        case (act)
            ACT_INSERT:
            begin
                if (shadow_count >= Capacity)
                    ans.st = ST_FULL;
                else
                begin
                    at = 0;
                    while (at < shadow_count && shadow_keys[at] < key)
                        at++;
                    for (int r = shadow_count; r > at; r--)
                    begin
                        shadow_keys[r]  = shadow_keys[r-1];
                        shadow_names[r] = shadow_names[r-1];
                    end
                    shadow_keys[at]  = key;
                    shadow_names[at] = nm;
                    shadow_count++;
                end
            end
            ACT_REM_TL:
            begin
                if (shadow_count == 0)
                    ans.st = ST_EMPTY;
                else
                    shadow_count--;
            end
            ACT_REM_NM:
            begin
                at = locate_name(nm);
                if (at < 0)
                    ans.st = ST_NOTFOUND;
                else
                begin
                    for (int k = at; k + 1 < shadow_count; k++)
                    begin
                        shadow_keys[k]  = shadow_keys[k+1];
                        shadow_names[k] = shadow_names[k+1];
                    end
                    shadow_count--;
                end
            end
            ACT_READ:
            begin
                if (pos < 1 || pos > shadow_count)
                    ans.st = ST_BADPOS;
                else
                    hit = pos - 1;
            end
            ACT_FIND:
            begin
                hit = locate_name(nm);
                if (hit < 0)
                    ans.st = ST_NOTFOUND;
            end
            default:
            begin
            end
        endcase
        ans.cnt = shadow_count[4:0];
        if (hit >= 0)
        begin
            ans.age = shadow_keys[hit];
            ans.nm  = shadow_names[hit];
        end
        else
        begin
            ans.age = '0;
            ans.nm  = '0;
        end
        return ans;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [255:0] got,
        input logic [255:0] want);
        $display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
        error_count++;
    endtask

    // Called at a falling edge; drop valid at the falling edge after the
    // transfer and return on a falling edge
    task automatic send_command(input logic [2:0] act, input logic [15:0] key,
        input logic [7:0] pos, input name_t raw, input bit use_gap);
        int gap;
        gap = use_gap ? pick_gap() : 0;
        repeat (gap)
            @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        age_key  <= key;
        position <= pos;
        name_w0  <= raw[63:0];
        name_w1  <= raw[127:64];
        name_w2  <= raw[191:128];
        name_w3  <= raw[255:192];
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_answers.push_back(apply_command(act, key, pos, raw));
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Pool entry, optionally with junk after its end that must be ignored
    function automatic name_t pool_variant(input int idx);
        name_t nm;
        bit    ended;
        nm    = name_pool[idx];
        ended = 1'b0;
        if ($urandom_range(0, 2) == 0)
        begin
            for (int b = 0; b < 32; b++)
            begin
                if (ended || b >= NameBytes)
                    nm[8*b +: 8] = 8'($urandom_range(0, 255));
                if (nm[8*b +: 8] == 8'h00 && b < NameBytes)
                    ended = 1'b1;
            end
        end
        return nm;
    endfunction

    function automatic name_t random_name();
        name_t nm;
        for (int w = 0; w < 8; w++)
            nm[32*w +: 32] = $urandom();
        return nm;
    endfunction

    task automatic test_empty_table();
        name_t nm;
        nm = name_pool[0];
        send_command(ACT_COUNT, 16'h0, 8'h0, '0, 1'b0);
        send_command(ACT_REM_TL, 16'h0, 8'h0, '0, 1'b0);
        send_command(ACT_REM_NM, 16'h0, 8'h0, nm, 1'b0);
        send_command(ACT_READ, 16'h0, 8'd0, '0, 1'b0);
        send_command(ACT_READ, 16'h0, 8'd1, '0, 1'b0);
        send_command(ACT_FIND, 16'h0, 8'h0, nm, 1'b0);
        send_command(3'd6, 16'hFFFF, 8'hFF, '1, 1'b0);
        send_command(3'd7, 16'h0, 8'h0, '0, 1'b0);
    endtask

    task automatic test_fill_and_drain();
        // Equal keys land newest first; extremes of the key at both ends
        for (int i = 0; i < Capacity; i++)
            send_command(ACT_INSERT, (i == 0) ? 16'hFFFF : (i < 4) ? 16'h0 : 16'(i * 3001),
                8'h0, (i == 5) ? '1 : name_pool[i % 12], 1'b0);
        send_command(ACT_INSERT, 16'h1234, 8'h0, name_pool[1], 1'b0);
        send_command(ACT_READ, 16'h0, 8'd1, '0, 1'b0);
        send_command(ACT_READ, 16'h0, 8'd16, '0, 1'b0);
        send_command(ACT_READ, 16'h0, 8'd17, '0, 1'b0);
        send_command(ACT_READ, 16'h0, 8'd255, '0, 1'b0);
        send_command(ACT_FIND, 16'h0, 8'h0, pool_variant(2), 1'b0);
        send_command(ACT_REM_NM, 16'h0, 8'h0, '1, 1'b0);
        send_command(ACT_REM_NM, 16'h0, 8'h0, name_pool[3], 1'b0);
        send_command(ACT_FIND, 16'h0, 8'h0, random_name(), 1'b0);
        send_command(ACT_REM_TL, 16'h0, 8'h0, '0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int          r;
        logic [2:0]  act;
        logic [7:0]  pos;
        name_t       nm;
        for (int n = 0; n < 1130; n++)
        begin
            r = $urandom_range(0, 99);
            // Lean on removals when the table is full so it keeps moving
            if (shadow_count == Capacity && r < 30)
                r = r + 35;
            if (r < 35)
                act = ACT_INSERT;
            else if (r < 45)
                act = ACT_REM_TL;
            else if (r < 60)
                act = ACT_REM_NM;
            else if (r < 75)
                act = ACT_READ;
            else if (r < 90)
                act = ACT_FIND;
            else
                act = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
                pos = 8'($urandom_range(0, 255));
            else
                pos = 8'($urandom_range(0, shadow_count + 1));
            if ($urandom_range(0, 9) == 0)
                nm = random_name();
            else
                nm = pool_variant($urandom_range(0, 11));
            send_command(act, 16'($urandom_range(0, 65535) & (($urandom_range(0, 3) == 0) ?
                16'h000F : 16'hFFFF)), pos, nm, 1'b1);
            // Quiet stretch with no receiver stalls now and then
            if (n % 200 == 100)
                stall_enable = ~stall_enable;
        end
    endtask

    // Receiver: compare each result with the oldest answer and stall at random
    initial
    begin
        table_answer_t want;
        name_t         got_name;
        int            hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got_name = {found_name_w3, found_name_w2, found_name_w1, found_name_w0};
                if (pending_answers.size() == 0)
                    report_mismatch("unexpected result", 256'(status), 256'h0);
                else
                begin
                    want = pending_answers.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 256'(status), 256'(want.st));
                    if (record_count !== want.cnt)
                        report_mismatch("record_count", 256'(record_count), 256'(want.cnt));
                    if (found_age !== want.age)
                        report_mismatch("found_age", 256'(found_age), 256'(want.age));
                    if (got_name !== want.nm)
                        report_mismatch("found_name", got_name, want.nm);
                end
            end
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (stall_enable)
                hold = pick_gap();
            out_stall <= (hold > 0);
        end
    end

    initial
    begin
        #20ms;
        $display("** sorted_record_table_core: FAILED **");
        $finish;
    end

    initial
    begin
        int waited;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        action       = '0;
        age_key      = '0;
        position     = '0;
        name_w0      = '0;
        name_w1      = '0;
        name_w2      = '0;
        name_w3      = '0;
        shadow_count = 0;
        error_count  = 0;
        stall_enable = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            name_pool[i] = '0;
            for (int b = 0; b < $urandom_range(1, 32); b++)
                name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_table();
        test_fill_and_drain();
        test_random_traffic();
        waited = 0;
        while (pending_answers.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * Capacity + 10) @(posedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("** sorted_record_table_core: PASSED **");
        else
            $display("** sorted_record_table_core: FAILED **");
        $finish;
    end

endmodule
